>>> design/zpb_pkg.sv
// ============================================================================
// zpb_pkg: shared types and constants for the zone proximity blend block
// Holds shape and register codes, loop lengths, blend constants and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package zpb_pkg;

    // zone shape codes
    localparam logic [1:0] SHAPE_SPHERE   = 2'd0;
    localparam logic [1:0] SHAPE_BOX      = 2'd1;
    localparam logic [1:0] SHAPE_CYLINDER = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SHAPE  = 3'd0;
    localparam logic [2:0] REG_CX     = 3'd1;
    localparam logic [2:0] REG_CY     = 3'd2;
    localparam logic [2:0] REG_CZ     = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;
    localparam logic [2:0] REG_EXT    = 3'd5;
    localparam logic [2:0] REG_FADE   = 3'd6;

    // iteration counts
    localparam logic [4:0] AXIS_STEPS = 5'd3;   // one square per axis
    localparam logic [4:0] ROOT_STEPS = 5'd21;  // one root bit per step
    localparam logic [4:0] DIV_STEPS  = 5'd13;  // one quotient bit per step

    // blend constants, Q2.12
    localparam logic [13:0] BLEND_ONE    = 14'd4096;
    localparam logic [13:0] SLEW_STEP    = 14'd131;
    localparam logic [13:0] ON_THRESHOLD = 14'd41;

    // distance saturation bounds
    localparam logic signed [23:0] DIST_MAX = 24'sd2097151;
    localparam logic signed [23:0] DIST_MIN = -24'sd2097152;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQ,
        S_RINIT,
        S_ROOT,
        S_DIST,
        S_DINIT,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       sq;
        logic [1:0] idx;
        logic       rinit;
        logic       root;
        logic       dclamp;
        logic       dinit;
        logic       div;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic need_div;
    } t_stat;

endpackage

>>> design/zpb_datapath.sv
// ============================================================================
// zpb_datapath: distance, fade and slew datapath
// Holds the zone registers, a shared squaring multiplier, a bit-serial
// square root, a bit-serial divider for the fade and the output register.
// ============================================================================
module zpb_datapath
    import zpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [59:0]         i_cfg_data,
    input  logic signed [19:0]  i_listener_x,
    input  logic signed [19:0]  i_listener_y,
    input  logic signed [19:0]  i_listener_z,
    input  logic                i_stall,
    output logic                o_valid,
    output logic signed [21:0]  o_surface_distance,
    output logic                o_inside_zone,
    output logic [12:0]         o_target_blend,
    output logic [12:0]         o_smoothed_blend,
    output logic                o_zone_on,
    output logic                o_start_event,
    output logic                o_stop_event
);

    // zone registers
    logic [1:0]         r_shape;
    logic signed [19:0] r_cx, r_cy, r_cz;
    logic [18:0]        r_radius;
    logic [59:0]        r_ext;
    logic [18:0]        r_fade;

    // working registers
    logic signed [20:0] r_dx, r_dy, r_dz;
    logic [19:0]        r_op [3];
    logic signed [20:0] r_mq;
    logic signed [20:0] r_qy;
    logic [41:0]        r_acc;
    logic [41:0]        r_rad;
    logic [21:0]        r_rem;
    logic [20:0]        r_root;
    logic signed [21:0] r_dist;
    logic [19:0]        r_drem;
    logic [12:0]        r_dlow;
    logic [12:0]        r_quo;

    // state and output
    logic [12:0]        r_level;
    logic               r_active;
    logic               r_out_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape  <= SHAPE_SPHERE;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= '0;
            r_ext    <= '0;
            r_fade   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHAPE:  r_shape  <= i_cfg_data[1:0];
                REG_CX:     r_cx     <= i_cfg_data[19:0];
                REG_CY:     r_cy     <= i_cfg_data[19:0];
                REG_CZ:     r_cz     <= i_cfg_data[19:0];
                REG_RADIUS: r_radius <= i_cfg_data[18:0];
                REG_EXT:    r_ext    <= i_cfg_data;
                REG_FADE:   r_fade   <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // per-axis magnitude and box offsets
    logic [20:0]        ax, ay, az;
    logic signed [20:0] qx, qy, qz;
    logic [19:0]        px, py, pz;
    logic signed [20:0] mxy, mq;

    always_comb begin
        ax = r_dx[20] ? 21'(-r_dx) : 21'(r_dx);
        ay = r_dy[20] ? 21'(-r_dy) : 21'(r_dy);
        az = r_dz[20] ? 21'(-r_dz) : 21'(r_dz);
        qx = $signed({1'b0, ax[19:0]}) - $signed({1'b0, r_ext[19:0]});
        qy = $signed({1'b0, ay[19:0]}) - $signed({1'b0, r_ext[39:20]});
        qz = $signed({1'b0, az[19:0]}) - $signed({1'b0, r_ext[59:40]});
        px = qx[20] ? 20'd0 : qx[19:0];
        py = qy[20] ? 20'd0 : qy[19:0];
        pz = qz[20] ? 20'd0 : qz[19:0];
        mxy = (qx > qy) ? qx : qy;
        mq  = (mxy > qz) ? mxy : qz;
    end

    // squaring multiplier, one axis per cycle
    logic [19:0] mul_in;
    logic [39:0] prod;
    assign mul_in = (i_cmd.idx == 2'd0) ? r_op[0] :
                    (i_cmd.idx == 2'd1) ? r_op[1] : r_op[2];
    assign prod = mul_in * mul_in;

    // square root step: bring down two bits
    logic [23:0] rt_rem, rt_trial;
    logic        rt_take;
    assign rt_rem   = {r_rem, r_rad[41:40]};
    assign rt_trial = {1'b0, r_root, 2'b01};
    assign rt_take  = rt_rem >= rt_trial;

    // signed distance per shape, then clamp
    logic signed [23:0] root_s, h_s, box_s, v_s, d_raw;
    always_comb begin
        root_s = $signed({3'b0, r_root});
        h_s    = root_s - $signed({5'b0, r_radius});
        box_s  = root_s + 24'(r_mq);
        v_s    = 24'(r_qy);
        case (r_shape)
            SHAPE_SPHERE:   d_raw = h_s;
            SHAPE_BOX:      d_raw = box_s;
            SHAPE_CYLINDER: d_raw = (h_s > v_s) ? h_s : v_s;
            default:        d_raw = '0;
        endcase
    end

    // fade division setup and step
    logic        dist_pos, need_div;
    logic [31:0] dnum;
    logic [19:0] dv_t;
    logic        dv_take;
    assign dist_pos = !r_dist[21] && (r_dist != '0);
    assign need_div = dist_pos && ($signed(r_dist) < $signed({3'b0, r_fade}));
    assign dnum     = {1'b0, r_dist[18:0], 12'b0} + {14'b0, r_fade[18:1]};
    assign dv_t     = {r_drem[18:0], r_dlow[12]};
    assign dv_take  = dv_t >= {1'b0, r_fade};

    // target, slew and activity
    logic signed [13:0] tgt, lvl, up_lim, dn_lim, nlvl;
    logic               n_active, start_ev, stop_ev;
    always_comb begin
        if (!dist_pos)
            tgt = BLEND_ONE;
        else if (!need_div)
            tgt = '0;
        else
            tgt = BLEND_ONE - {1'b0, r_quo};
        lvl    = {1'b0, r_level};
        up_lim = lvl + SLEW_STEP;
        dn_lim = lvl - SLEW_STEP;
        if (tgt > lvl)
            nlvl = (tgt < up_lim) ? tgt : up_lim;
        else
            nlvl = (tgt > dn_lim) ? tgt : dn_lim;
        start_ev = (nlvl > $signed(ON_THRESHOLD)) && !r_active;
        stop_ev  = !start_ev && (nlvl < $signed(ON_THRESHOLD)) && r_active;
        n_active = start_ev ? 1'b1 : (stop_ev ? 1'b0 : r_active);
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= 21'(i_listener_x) - 21'(r_cx);
            r_dy <= 21'(i_listener_y) - 21'(r_cy);
            r_dz <= 21'(i_listener_z) - 21'(r_cz);
        end
        if (i_cmd.prep) begin
            r_acc <= '0;
            r_mq  <= mq[20] ? mq : 21'sd0;
            r_qy  <= qy;
            case (r_shape)
                SHAPE_BOX: begin
                    r_op[0] <= px;
                    r_op[1] <= py;
                    r_op[2] <= pz;
                end
                SHAPE_CYLINDER: begin
                    r_op[0] <= ax[19:0];
                    r_op[1] <= '0;
                    r_op[2] <= az[19:0];
                end
                default: begin
                    r_op[0] <= ax[19:0];
                    r_op[1] <= ay[19:0];
                    r_op[2] <= az[19:0];
                end
            endcase
        end
        if (i_cmd.sq)
            r_acc <= r_acc + {2'b0, prod};
        if (i_cmd.rinit) begin
            r_rad  <= r_acc;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.root) begin
            r_rad  <= {r_rad[39:0], 2'b00};
            r_rem  <= rt_take ? 22'(rt_rem - rt_trial) : rt_rem[21:0];
            r_root <= {r_root[19:0], rt_take};
        end
        if (i_cmd.dclamp) begin
            if (d_raw > DIST_MAX)
                r_dist <= DIST_MAX[21:0];
            else if (d_raw < DIST_MIN)
                r_dist <= DIST_MIN[21:0];
            else
                r_dist <= d_raw[21:0];
        end
        if (i_cmd.dinit) begin
            r_drem <= {1'b0, dnum[31:13]};
            r_dlow <= dnum[12:0];
            r_quo  <= '0;
        end
        if (i_cmd.div) begin
            r_drem <= dv_take ? (dv_t - {1'b0, r_fade}) : dv_t;
            r_dlow <= {r_dlow[11:0], 1'b0};
            r_quo  <= {r_quo[11:0], dv_take};
        end
    end

    // blend state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.commit) begin
            r_level  <= nlvl[12:0];
            r_active <= n_active;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.commit)
            r_out_valid <= 1'b1;
        else if (!i_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_surface_distance <= r_dist;
            o_inside_zone      <= !dist_pos;
            o_target_blend     <= tgt[12:0];
            o_smoothed_blend   <= nlvl[12:0];
            o_zone_on          <= n_active;
            o_start_event      <= start_ev;
            o_stop_event       <= stop_ev;
        end
    end

    assign o_valid = r_out_valid;
    assign o_stat  = '{out_free: !r_out_valid || !i_stall, need_div: need_div};

endmodule

>>> design/zpb_ctrl.sv
// ============================================================================
// zpb_ctrl: sequencer for the zone proximity blend
// Steps one listener position through prep, squaring, root, distance,
// fade division when needed and commit, counting the iterative phases.
// ============================================================================
module zpb_ctrl
    import zpb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq  = 1'b1;
                o_cmd.idx = r_cnt[1:0];
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == AXIS_STEPS - 5'd1)
                    n_state = S_RINIT;
            end
            S_RINIT: begin
                o_cmd.rinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_cnt      = r_cnt + 5'd1;
                if (r_cnt == ROOT_STEPS - 5'd1)
                    n_state = S_DIST;
            end
            S_DIST: begin
                o_cmd.dclamp = 1'b1;
                n_state      = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.dinit = 1'b1;
                n_cnt       = '0;
                n_state     = i_stat.need_div ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == DIV_STEPS - 5'd1)
                    n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a request always moves on to prep
    a_load_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_PREP)
        else $error("load not followed by prep");

    // root count never overruns
    a_root_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT |-> r_cnt < ROOT_STEPS)
        else $error("root counter overrun");

    // commit only into a free output slot
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.out_free)
        else $error("commit into occupied output");

    // a commit returns the sequencer to idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_state == S_IDLE)
        else $error("commit not followed by idle");

endmodule

>>> design/zone_proximity_blend.sv
// ============================================================================
// zone_proximity_blend: listener proximity blend against one ambient zone
// Signed distance to a sphere, box or cylinder, linear fade to a target
// blend, slew-limited blend level and start/stop events.
// ============================================================================
// Usage:
//   Configuration: write register index/data on i_cfg_*; always ready.
//   Write only while the block is idle.
//   Input: one listener position per request, taken when i_valid is high
//   and o_stall is low. o_stall is high while a request is being worked.
//   Output: one result per request on o_valid, held while i_stall is high.
//   Steps from accept to o_valid: prep, squaring of each axis, root
//   setup, the bit-serial square root, clamp, divider setup, the
//   bit-serial fade divider (only when a fade division is needed) and
//   the commit. A new request is taken only once the sequencer is back
//   in idle after the commit. A stalled result holds the sequencer in
//   its final step until the output register frees, so the next request
//   waits too.
//   Reset clears the zone registers, the blend level and the active flag.
// ============================================================================
module zone_proximity_blend
    import zpb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [59:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [19:0]  i_listener_x,
    input  logic signed [19:0]  i_listener_y,
    input  logic signed [19:0]  i_listener_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [21:0]  o_surface_distance,
    output logic                o_inside_zone,
    output logic [12:0]         o_target_blend,
    output logic [12:0]         o_smoothed_blend,
    output logic                o_zone_on,
    output logic                o_start_event,
    output logic                o_stop_event
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    zpb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    zpb_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_listener_x       (i_listener_x),
        .i_listener_y       (i_listener_y),
        .i_listener_z       (i_listener_z),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_surface_distance (o_surface_distance),
        .o_inside_zone      (o_inside_zone),
        .o_target_blend     (o_target_blend),
        .o_smoothed_blend   (o_smoothed_blend),
        .o_zone_on          (o_zone_on),
        .o_start_event      (o_start_event),
        .o_stop_event       (o_stop_event)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for zone_proximity_blend
// Drives listener positions under several zone settings, predicts distance,
// target blend, slewed level and start/stop events, and compares every result.
// ============================================================================
module tb;
    import zpb_pkg::*;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [21:0] sdist;
        logic               in_zone;
        logic [12:0]        target;
        logic [12:0]        level;
        logic               on;
        logic               start;
        logic               stop;
    } t_blend;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [59:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [19:0] i_listener_x;
    logic signed [19:0] i_listener_y;
    logic signed [19:0] i_listener_z;
    logic               o_valid;
    logic               i_stall;
    logic signed [21:0] o_surface_distance;
    logic               o_inside_zone;
    logic [12:0]        o_target_blend;
    logic [12:0]        o_smoothed_blend;
    logic               o_zone_on;
    logic               o_start_event;
    logic               o_stop_event;

    zone_proximity_blend uut (.*);

    // predictor copy of the zone registers and blend state
    logic [1:0]         zone_shape;
    logic signed [63:0] cen_x, cen_y, cen_z;
    logic [63:0]        radius, fade;
    logic [59:0]        extents;
    logic signed [63:0] level_q;
    logic               on_q;

    t_pos   pos_queue[$];
    t_blend blend_queue[$];
    int     send_idle_pct, recv_idle_pct;
    int     hold_cycles;
    int     errors, checked, starts, stops;
    int     shape_seen[4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("TIMEOUT");
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] mag(input logic signed [63:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic signed [63:0] smax(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        return a > b ? a : b;
    endfunction

    // signed distance to the zone surface, unsaturated
    function automatic logic signed [63:0] zone_dist(input logic signed [63:0] dx,
                                                     input logic signed [63:0] dy,
                                                     input logic signed [63:0] dz);
        logic signed [63:0] ex, ey, ez, qx, qy, qz, h, m;
        ex = {44'd0, extents[19:0]};
        ey = {44'd0, extents[39:20]};
        ez = {44'd0, extents[59:40]};
        case (zone_shape)
            SHAPE_SPHERE:
                return $signed(int_sqrt(dx * dx + dy * dy + dz * dz)) - $signed(radius);
            SHAPE_BOX: begin
                qx = mag(dx) - ex;
                qy = mag(dy) - ey;
                qz = mag(dz) - ez;
                m = smax(qx, smax(qy, qz));
                if (m > 0) m = 0;
                qx = smax(qx, 0);
                qy = smax(qy, 0);
                qz = smax(qz, 0);
                return $signed(int_sqrt(qx * qx + qy * qy + qz * qz)) + m;
            end
            SHAPE_CYLINDER: begin
                h = $signed(int_sqrt(dx * dx + dz * dz)) - $signed(radius);
                return smax(h, mag(dy) - ey);
            end
            default: return 0;
        endcase
    endfunction

    // one frame tick: advances the level and activity flag
    function automatic t_blend blend_tick(input t_pos p);
        t_blend r;
        logic signed [63:0] d, tgt;
        d = zone_dist(64'(p.x) - cen_x, 64'(p.y) - cen_y, 64'(p.z) - cen_z);
        if (d > 2097151) d = 2097151;
        if (d < -2097152) d = -2097152;
        if (d <= 0) tgt = 4096;
        else if (d >= $signed(fade)) tgt = 0;
        else tgt = 4096 - (d * 4096 + $signed(fade / 2)) / $signed(fade);
        if (tgt > level_q) level_q = (tgt < level_q + 131) ? tgt : level_q + 131;
        else level_q = (tgt > level_q - 131) ? tgt : level_q - 131;
        r.start = 0;
        r.stop = 0;
        if (level_q > 41 && !on_q) begin
            on_q = 1;
            r.start = 1;
        end else if (level_q < 41 && on_q) begin
            on_q = 0;
            r.stop = 1;
        end
        r.sdist = d[21:0];
        r.in_zone = d <= 0;
        r.target = tgt[12:0];
        r.level = level_q[12:0];
        r.on = on_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp, checked);
    endtask

    // append one listener position to the pending list
    task automatic queue_pos(input t_pos p);
        pos_queue = {pos_queue, p};
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pos_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                {i_listener_x, i_listener_y, i_listener_z} <= pos_queue[0];
                blend_queue = {blend_queue, blend_tick(pos_queue.pop_front())};
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_blend e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (blend_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = blend_queue.pop_front();
                if (o_surface_distance != e.sdist)
                    report_mismatch("surface_distance", o_surface_distance, e.sdist);
                if (o_inside_zone != e.in_zone)
                    report_mismatch("inside_zone", o_inside_zone, e.in_zone);
                if (o_target_blend != e.target)
                    report_mismatch("target_blend", o_target_blend, e.target);
                if (o_smoothed_blend != e.level)
                    report_mismatch("smoothed_blend", o_smoothed_blend, e.level);
                if (o_zone_on != e.on) report_mismatch("zone_on", o_zone_on, e.on);
                if (o_start_event != e.start)
                    report_mismatch("start_event", o_start_event, e.start);
                if (o_stop_event != e.stop)
                    report_mismatch("stop_event", o_stop_event, e.stop);
                starts += e.start;
                stops += e.stop;
            end
            checked++;
        end
    end

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SHAPE:  zone_shape = val[1:0];
            REG_CX:     cen_x = 64'($signed(val[19:0]));
            REG_CY:     cen_y = 64'($signed(val[19:0]));
            REG_CZ:     cen_z = 64'($signed(val[19:0]));
            REG_RADIUS: radius = {45'd0, val[18:0]};
            REG_EXT:    extents = val;
            REG_FADE:   fade = {45'd0, val[18:0]};
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pos_queue.size() != 0 || blend_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_zone(input logic [1:0] shp, input logic [19:0] cx,
                            input logic [19:0] cy, input logic [19:0] cz,
                            input logic [18:0] rad, input logic [59:0] ext,
                            input logic [18:0] fd);
        write_reg(REG_SHAPE, 60'(shp));
        write_reg(REG_CX, 60'(cx));
        write_reg(REG_CY, 60'(cy));
        write_reg(REG_CZ, 60'(cz));
        write_reg(REG_RADIUS, 60'(rad));
        write_reg(REG_EXT, ext);
        write_reg(REG_FADE, 60'(fd));
        shape_seen[shp]++;
    endtask

    function automatic logic [19:0] near_coord(input logic [19:0] c, input int span);
        return c + 20'($signed($urandom_range(2 * span)) - span);
    endfunction

    // random listener path: mostly near the zone so the blend sweeps fully
    task automatic queue_walk(input int n, input int span);
        t_pos p;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                p = 60'({$urandom, $urandom});
            end else begin
                p.x = near_coord(cen_x[19:0], span);
                p.y = near_coord(cen_y[19:0], span);
                p.z = near_coord(cen_z[19:0], span);
            end
            queue_pos(p);
        end
    endtask

    task automatic random_zone();
        logic [18:0] r;
        r = 19'($urandom_range(6000));
        set_zone(2'($urandom_range(3)), 20'($urandom_range(4000)) - 20'd2000,
                 20'($urandom), 20'($urandom_range(4000)) - 20'd2000, r,
                 {20'($urandom_range(3000)), 20'($urandom_range(3000)),
                  20'($urandom_range(3000))},
                 ($urandom_range(4) == 0) ? 19'd0 : 19'($urandom_range(8000)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_listener_x = '0;
        i_listener_y = '0;
        i_listener_z = '0;
        zone_shape = SHAPE_SPHERE;
        cen_x = 0; cen_y = 0; cen_z = 0;
        radius = 0; fade = 0; extents = 0;
        level_q = 0; on_q = 0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
        errors = 0; checked = 0; starts = 0; stops = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset zone, extreme corners, undefined shape, zero fade
        queue_pos('0);
        queue_pos({20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        queue_pos({20'h80000, 20'h80000, 20'h80000});
        queue_pos({20'h80000, 20'h7FFFF, 20'hFFFFF});
        wait_idle();
        // far corner of a zero-radius sphere: largest reachable distance
        set_zone(SHAPE_SPHERE, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 19'h00000,
                 60'd0, 19'h7FFFF);
        queue_pos({20'h80000, 20'h80000, 20'h80000});
        queue_pos({20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        wait_idle();
        set_zone(SHAPE_BOX, 20'h80000, 20'h80000, 20'h80000, 19'h7FFFF,
                 60'hFFFFFFFFFFFFFFF, 19'd0);
        queue_pos({20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        queue_pos({20'h80000, 20'h80000, 20'h80000});
        wait_idle();
        // undefined shape code always counts as inside; unknown index ignored
        set_zone(2'd3, 20'd0, 20'd0, 20'd0, 19'd100, 60'd0, 19'd100);
        write_reg(3'd7, 60'hFFFFFFFFFFFFFFF);
        for (int i = 0; i < 6; i++) queue_pos(60'({$urandom, $urandom}));
        wait_idle();
        // fade: a fixed listener inside the fade band, giving a partial target blend
        set_zone(SHAPE_CYLINDER, 20'd0, 20'd0, 20'd0, 19'd256, {20'd0, 20'd512, 20'd0},
                 19'd4096);
        for (int i = 0; i < 5; i++) queue_pos({20'd3000, 20'd0, 20'd0});
        wait_idle();

        // random phases under the three idling schemes
        for (int ph = 0; ph < 30; ph++) begin
            if (ph < 10) begin
                send_idle_pct = 14; recv_idle_pct = 83;
            end else if (ph < 20) begin
                send_idle_pct = 83; recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_zone();
            if (ph == 22) hold_cycles = 400;
            queue_walk(41, 1 + 8000 * (ph % 3));
            wait_idle();
        end

        $display("Covered %0d ticks over sphere/box/cylinder/undefined = %0d/%0d/%0d/%0d",
                 checked, shape_seen[0], shape_seen[1], shape_seen[2], shape_seen[3]);
        $display("Saw %0d start and %0d stop events, stalls both ways", starts, stops);
        if (errors == 0 && blend_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/zpb_pkg.sv
design/zpb_datapath.sv
design/zpb_ctrl.sv
design/zone_proximity_blend.sv
sim/tb.sv
